// ===== src/ufd_pkg.sv =====
package ufd_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;

	// offsets of the big-endian payload length inside the head
	localparam logic [16:0] LEN_HI_OFS = 17'd4;
	localparam logic [16:0] LEN_LO_OFS = 17'd5;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADSUM   = 2'd1,
		ST_OVERSIZE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ARMED,
		PH_HEAD,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [16:0] byte_index;
		logic        last;
		status_t     status;
	} result_t;

	// up to two results per accepted item; r1 only with r0
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

endpackage

// ===== src/ufd_parser.sv =====
module ufd_parser import ufd_pkg::*; #(
	parameter int HEADER_LEN = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output push_t       push
);

	localparam logic [16:0] HL = 17'(HEADER_LEN);

	phase_t      phase_q, phase_d;
	logic [15:0] len_q, len_d, len_full;
	logic [16:0] cnt_q, cnt_d, cnt_inc;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			max_q   <= 16'd1024;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
		end
	end

	assign cnt_inc = cnt_q + 17'd1;

	// length as it stands after this head byte
	always_comb begin
		if (cnt_q == LEN_HI_OFS) begin
			len_full = {rx_byte, 8'h00};
		end else if (cnt_q == LEN_LO_OFS) begin
			len_full = {len_q[15:8], rx_byte};
		end else begin
			len_full = len_q;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		push    = '0;
		push.r0 = '{frame_byte: rx_byte, byte_index: cnt_q, last: 1'b0, status: ST_OK};
		push.r1 = '{frame_byte: SYNC_SECOND, byte_index: 17'd1, last: 1'b0, status: ST_OK};
		if (acc) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == SYNC_FIRST) begin
						phase_d = PH_ARMED;
					end
				end
				PH_ARMED: begin
					if (rx_byte == SYNC_SECOND) begin
						push.v0 = 1'b1;
						push.v1 = 1'b1;
						push.r0 = '{frame_byte: SYNC_FIRST, byte_index: 17'd0,
							last: 1'b0, status: ST_OK};
						sum_d   = SYNC_FIRST + SYNC_SECOND;
						cnt_d   = 17'd2;
						len_d   = '0;
						phase_d = PH_HEAD;
					end else if (rx_byte != SYNC_FIRST) begin
						phase_d = PH_HUNT;
					end
				end
				PH_HEAD: begin
					push.v0 = 1'b1;
					if (cnt_q == LEN_LO_OFS && len_full > max_q) begin
						// declared length too large: close the frame here
						push.r0.last   = 1'b1;
						push.r0.status = ST_OVERSIZE;
						phase_d = PH_HUNT;
						len_d   = '0;
						cnt_d   = '0;
						sum_d   = '0;
					end else begin
						len_d = len_full;
						sum_d = sum_q + rx_byte;
						cnt_d = cnt_inc;
						if (cnt_inc >= HL) begin
							phase_d = (cnt_inc >= HL + {1'b0, len_full}) ? PH_CHECK
								: PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					push.v0 = 1'b1;
					sum_d   = sum_q + rx_byte;
					cnt_d   = cnt_inc;
					if (cnt_inc >= HL + {1'b0, len_q}) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					push.v0 = 1'b1;
					push.r0.last   = 1'b1;
					push.r0.status = (rx_byte == sum_q) ? ST_OK : ST_BADSUM;
					phase_d = PH_HUNT;
					len_d   = '0;
					cnt_d   = '0;
					sum_d   = '0;
				end
				default: begin
					phase_d = PH_HUNT;
					len_d   = '0;
					cnt_d   = '0;
					sum_d   = '0;
				end
			endcase
		end
	end

endmodule

// ===== src/ufd_res_fifo.sv =====
module ufd_res_fifo import ufd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output result_t head,
	output logic    not_empty,
	output logic    room2
);

	result_t                mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wptr_q, rptr_q;
	logic [RES_CNT_W-1:0]   cnt_q;
	logic [RES_CNT_W-1:0]   n_wr;

	assign n_wr      = RES_CNT_W'(push.v0) + RES_CNT_W'(push.v1);
	assign not_empty = cnt_q != '0;
	assign room2     = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wptr_q + RES_PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + RES_PTR_W'(n_wr);
			if (pop) begin
				rptr_q <= rptr_q + RES_PTR_W'(1);
			end
			cnt_q <= cnt_q + n_wr - RES_CNT_W'(pop);
		end
	end

endmodule

// ===== src/uart_frame_deframer_sum8.sv =====
// Frame parser for 0x55 0xAA / length / sum8 serial frames.
// Results pass through the result queue, whose head entry drives the output.
// Throughput: one item per cycle while not stalled; the header-confirm item makes
// two results, so the 4-entry queue raises in_stall when under two slots are free.
// Reset (arst_n low, asynchronous): hunt for header, counters and sum cleared,
// result queue emptied, max_payload_len back to 1024.
module uart_frame_deframer_sum8 import ufd_pkg::*; #(
	parameter int HEADER_LEN = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic [16:0] byte_index,
	output logic        last,
	output logic [1:0]  status,
	// max_payload_len register
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	push_t   push;
	result_t head;
	logic    room2;
	logic    acc;
	logic    pop;

	// the queue must take a full two-result push before an item is taken
	assign in_stall = !room2;
	assign acc      = in_valid && room2;
	assign pop      = out_valid && !out_stall;

	// phase tracking, length capture, sum and status for one item
	ufd_parser #(
		.HEADER_LEN (HEADER_LEN)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.rx_byte     (rx_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push)
	);

	// result queue doubles as output register; head entry is the output item
	ufd_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (out_valid),
		.room2     (room2)
	);

	assign frame_byte = head.frame_byte;
	assign byte_index = head.byte_index;
	assign last       = head.last;
	assign status     = head.status;

endmodule

// ===== src/ufd_checker.sv =====
module ufd_checker import ufd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  frame_byte,
	input logic [16:0] byte_index,
	input logic        last,
	input logic [1:0]  status
);

	// status only on the closing item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_OK)
		else $error("status set on non-final item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BADSUM || status == ST_OVERSIZE))
		else $error("undefined status code");

	// a frame always opens with the sync byte and is never closed on it
	a_frame_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_index == 17'd0 |-> frame_byte == SYNC_FIRST && !last)
		else $error("frame index 0 is not the first sync byte");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_byte)
			&& $stable(byte_index) && $stable(last) && $stable(status))
		else $error("stalled output item changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input item changed");

endmodule

bind uart_frame_deframer_sum8 ufd_checker u_chk (.*);
